/* design/tdpt_pkg.sv */
// ----------------------------------------------------------------------------
// tdpt_pkg: shared constants for the trial division prime test unit
// Default operand width and the start values of the divisor walk.
// ----------------------------------------------------------------------------
package tdpt_pkg;

    // default operand width in bits (legal range 8 to 64)
    localparam int NUMBER_WIDTH_DEF = 32;

    // first odd trial divisor and its square
    localparam int FIRST_DIVISOR = 3;
    localparam int FIRST_SQUARE  = 9;

    // smallest prime, and the step between odd divisors
    localparam int SMALLEST_PRIME = 2;
    localparam int DIVISOR_STEP   = 2;

endpackage

/* design/trial_division_prime_test_unit.sv */
// ----------------------------------------------------------------------------
// trial_division_prime_test_unit: primality test by trial division
//
// Input channel (in_valid / in_stall / number) takes one word: an unsigned
// NUMBER_WIDTH-bit value. Output channel (out_valid / out_stall / is_prime)
// returns one word per input word: 1 for prime, 0 for composite, 0 or 1.
// A word moves on a rising edge with valid high and stall low.
//
// Flow: 0, 1 and even numbers go straight from idle to finish. An odd n >= 3
// is divided by 3, 5, 7, ... while d*d <= n. Each divisor takes one bound
// check plus one pass of a shared restoring divider over all NUMBER_WIDTH
// dividend bits (one remainder bit per cycle); at most sqrt(n)/2 divisors
// are tried. The divider loop sets the throughput; one number is in
// flight at a time and in_stall is high until its result is registered.
//
// The output register decouples the sides: a new number is accepted while a
// previous result still waits under out_stall; a finished result then waits
// in its own state until the output register frees up.
// Reset (rst_n low, asynchronous) empties the output and returns to idle.
// ----------------------------------------------------------------------------
module trial_division_prime_test_unit
#(
    parameter int NUMBER_WIDTH = tdpt_pkg::NUMBER_WIDTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [NUMBER_WIDTH-1:0] number,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    is_prime
);

    import tdpt_pkg::*;

    // divisor width: d never exceeds 2^ceil(W/2) + 1
    localparam int DW  = (NUMBER_WIDTH + 1) / 2 + 1;
    // square of the divisor
    localparam int SQW = 2 * DW;
    // remainder holds up to 2*d - 1 before the subtract
    localparam int RW  = DW + 1;
    // bit counter for one division pass
    localparam int CW  = $clog2(NUMBER_WIDTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BOUND,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t                  state_reg;
    logic [NUMBER_WIDTH-1:0] cand_reg;     // number under test
    logic [NUMBER_WIDTH-1:0] shift_reg;    // dividend bits, msb first
    logic [DW-1:0]           div_reg;      // current odd divisor
    logic [SQW-1:0]          sq_reg;       // div_reg squared
    logic [RW-1:0]           rem_reg;      // partial remainder
    logic [CW-1:0]           cnt_reg;      // bits left in this pass
    logic                    result_reg;   // pending verdict
    logic                    out_valid_reg;
    logic                    is_prime_reg;

    // divider step: shift in next bit, subtract if it fits
    logic [RW-1:0]  rem_shift;
    logic [RW-1:0]  rem_next;
    logic           rem_fits;

    // incremental square: (d+2)^2 = d^2 + 4d + 4
    logic [SQW-1:0] sq_next;
    logic [DW-1:0]  div_next;

    // trivial cases, decoded on the input word
    logic           num_lt2;
    logic           num_is2;
    logic           num_even;
    logic           out_free;

    assign rem_shift = {rem_reg[RW-2:0], shift_reg[NUMBER_WIDTH-1]};
    assign rem_fits  = rem_shift >= {1'b0, div_reg};
    assign rem_next  = rem_fits ? (rem_shift - {1'b0, div_reg}) : rem_shift;

    assign div_next  = div_reg + DW'(DIVISOR_STEP);
    assign sq_next   = sq_reg + {{(SQW-DW-2){1'b0}}, div_reg, 2'b00} + SQW'(4);

    assign num_lt2   = number < NUMBER_WIDTH'(SMALLEST_PRIME);
    assign num_is2   = number == NUMBER_WIDTH'(SMALLEST_PRIME);
    assign num_even  = ~number[0];

    assign out_free  = ~out_valid_reg | ~out_stall;

    assign in_stall  = state_reg != ST_IDLE;
    assign out_valid = out_valid_reg;
    assign is_prime  = is_prime_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            is_prime_reg  <= 1'b0;
            cand_reg      <= '0;
            shift_reg     <= '0;
            div_reg       <= DW'(FIRST_DIVISOR);
            sq_reg        <= SQW'(FIRST_SQUARE);
            cnt_reg       <= '0;
            rem_reg       <= '0;
            result_reg    <= 1'b0;
        end
        else
        begin
            // output register: loads a finished verdict, else drains
            if (state_reg == ST_FINISH && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        cand_reg <= number;
                        div_reg  <= DW'(FIRST_DIVISOR);
                        sq_reg   <= SQW'(FIRST_SQUARE);
                        if (num_lt2 || num_is2 || num_even)
                        begin
                            result_reg <= num_is2;
                            state_reg  <= ST_FINISH;
                        end
                        else
                        begin
                            state_reg <= ST_BOUND;
                        end
                    end
                end

                ST_BOUND:
                begin
                    // all divisors up to sqrt(n) tried: prime
                    if (sq_reg > SQW'(cand_reg))
                    begin
                        result_reg <= 1'b1;
                        state_reg  <= ST_FINISH;
                    end
                    else
                    begin
                        shift_reg <= cand_reg;
                        rem_reg   <= '0;
                        cnt_reg   <= CW'(NUMBER_WIDTH - 1);
                        state_reg <= ST_DIV;
                    end
                end

                ST_DIV:
                begin
                    rem_reg   <= rem_next;
                    shift_reg <= {shift_reg[NUMBER_WIDTH-2:0], 1'b0};
                    cnt_reg   <= cnt_reg - CW'(1);
                    if (cnt_reg == '0)
                    begin
                        if (rem_next == '0)
                        begin
                            result_reg <= 1'b0;
                            state_reg  <= ST_FINISH;
                        end
                        else
                        begin
                            div_reg   <= div_next;
                            sq_reg    <= sq_next;
                            state_reg <= ST_BOUND;
                        end
                    end
                end

                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        is_prime_reg  <= result_reg;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // divisor walk stays on odd values
    a_div_odd: assert property (@(posedge clk) disable iff (!rst_n)
        div_reg[0])
        else $error("trial divisor became even");

    // running square tracks the divisor
    a_sq_track: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_BOUND |-> sq_reg == SQW'(div_reg) * SQW'(div_reg))
        else $error("divisor square out of step");

    // restoring divider keeps remainder below divisor
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> rem_reg < {1'b0, div_reg})
        else $error("partial remainder not below divisor");

    // a division pass ends after its last bit
    a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && cnt_reg == '0) |=> state_reg != ST_DIV)
        else $error("division pass overran");

    // a finished verdict is never dropped over a busy output
    a_finish_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && !out_free) |=> state_reg == ST_FINISH)
        else $error("result left finish state while output was busy");

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb: testbench for trial_division_prime_test_unit
// Sends numbers one word at a time and compares each is_prime word with a
// trial-division verdict computed here. Numbers come from a directed list of
// edge values, then a random mix biased toward cheap tests.
// ----------------------------------------------------------------------------
module tb;

    import tdpt_pkg::*;

    localparam int WIDTH            = NUMBER_WIDTH_DEF;
    localparam int EDGE_COUNT       = 22;
    localparam int RANDOM_WORDS     = 600;
    // long output hold-off, started once enough words went in
    localparam int HOLD_AFTER_WORDS = 40;
    localparam int HOLD_CYCLES      = 2000;
    // settle time after the last result
    localparam int DRAIN_CYCLES     = 200;

    // which side idles how often
    typedef enum int
    {
        IDLE_MOSTLY_RX,
        IDLE_MOSTLY_TX,
        IDLE_NONE
    } idle_mode_t;

    typedef struct
    {
        logic [WIDTH-1:0] value;
        bit               prime;
    } verdict_t;

    // ------------------------------------------------------------------------
    // Expected verdicts in acceptance order, plus the predictor.
    // ------------------------------------------------------------------------
    class verdict_ledger;
        verdict_t pending_verdicts[$];
        int       mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        // odd divisors from 3 while d <= n / d; no product can overflow
        static function bit trial_division_verdict(logic [WIDTH-1:0] value);
            bit [63:0] n;
            bit [63:0] d;
            bit        prime;
            n     = value;
            d     = FIRST_DIVISOR;
            prime = 1'b1;
            if (n < SMALLEST_PRIME)
                prime = 1'b0;
            else if (n == SMALLEST_PRIME)
                prime = 1'b1;
            else if (n % 2 == 0)
                prime = 1'b0;
            else
            begin
                while (prime && d <= n / d)
                begin
                    if (n % d == 0)
                        prime = 1'b0;
                    d += DIVISOR_STEP;
                end
            end
            return prime;
        endfunction

        task report_mismatch(string msg);
            mismatch_count++;
            $display("MISMATCH @%0t: %s", $time, msg);
        endtask

        function void note_number(logic [WIDTH-1:0] value);
            verdict_t v;
            v.value = value;
            v.prime = trial_division_verdict(value);
            pending_verdicts.push_back(v);
        endfunction

        task check_verdict(logic got);
            verdict_t v;
            if (pending_verdicts.size() == 0)
            begin
                report_mismatch($sformatf("is_prime=%b with no number pending", got));
                return;
            end
            v = pending_verdicts.pop_front();
            if (got !== v.prime)
                report_mismatch($sformatf("number %0d: is_prime=%b, want %b",
                                          v.value, got, v.prime));
        endtask

        function int pending_count();
            return pending_verdicts.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic [WIDTH-1:0] number;
    logic             out_valid;
    logic             out_stall;
    logic             is_prime;

    verdict_ledger ledger = new();
    idle_mode_t    idle_mode;
    int            words_in = 0;

    trial_division_prime_test_unit #(.NUMBER_WIDTH(WIDTH)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .number    (number),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .is_prime  (is_prime)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // percent of cycles each side idles in the current mode
    function automatic int send_idle_pct();
        case (idle_mode)
            IDLE_MOSTLY_RX: return 34;
            IDLE_MOSTLY_TX: return 74;
            default:        return 0;
        endcase
    endfunction

    function automatic int recv_idle_pct();
        case (idle_mode)
            IDLE_MOSTLY_RX: return 74;
            IDLE_MOSTLY_TX: return 34;
            default:        return 0;
        endcase
    endfunction

    // Edge values: 0/1/2, small primes and odd squares (divisor bound hit
    // exactly), all-ones/all-zeros-ish patterns, largest 16-bit prime, and
    // a couple of slow primes to exercise long divisor walks.
    function automatic logic [WIDTH-1:0] edge_number(int idx);
        case (idx)
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return 32'd2;
            3:       return 32'd3;
            4:       return 32'd4;
            5:       return 32'd5;
            6:       return 32'd9;
            7:       return 32'd15;
            8:       return 32'd25;
            9:       return 32'd49;
            10:      return 32'd97;
            11:      return 32'd121;
            12:      return 32'd7919;
            13:      return 32'd65521;
            14:      return 32'd1048573;
            15:      return 32'd16777213;
            16:      return 32'hFFFE_0001;   // 65535 squared
            17:      return 32'h8000_0000;
            18:      return 32'h5555_5555;
            19:      return 32'hAAAA_AAAA;
            20:      return 32'hFFFF_FFFE;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // Random mix. Cost grows with the smallest factor, so full-width odd
    // values are built as multiples of a small odd number; full-width
    // primes would walk the whole divisor range up to sqrt(n).
    function automatic logic [WIDTH-1:0] pick_number();
        int unsigned sel;
        int unsigned p;
        int unsigned d;
        int unsigned n;
        sel = $urandom_range(99);
        if (sel < 45)
            n = $urandom_range(1023);
        else if (sel < 60)
            n = $urandom_range(65535);
        else if (sel < 85)
        begin
            n = $urandom;
            if (n[0])
            begin
                p = 2 * $urandom_range(1, 6) + 1;
                n = p * $urandom_range(32'hFFFF_FFFF / p);
            end
        end
        else
        begin
            // odd square or a neighbor two away: bound check at its edge
            d = 2 * $urandom_range(1, 127) + 1;
            n = d * d + 2 * $urandom_range(2) - 2;
        end
        return n;
    endfunction

    // One word on the input channel; payload held until accepted.
    task automatic send_number(input logic [WIDTH-1:0] value);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct())
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        number   <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        ledger.note_number(value);
        words_in++;
    endtask

    // Output side: random stall per mode, plus one long hold-off that lets
    // the output register and the finished-result slot fill so that in_stall
    // backs up to the sender.
    initial
    begin
        bit hold_taken;
        hold_taken = 1'b0;
        out_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_taken && words_in >= HOLD_AFTER_WORDS)
            begin
                hold_taken = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct());
        end
    end

    // result monitor: a word moves when valid is high and stall is low
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            ledger.check_verdict(is_prime);
    end

    // main sequence
    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        number    = '0;
        idle_mode = IDLE_MOSTLY_RX;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < EDGE_COUNT; i++)
            send_number(edge_number(i));

        // three equal stretches: receiver-heavy idling, sender-heavy, none
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i == RANDOM_WORDS / 3)
                idle_mode = IDLE_MOSTLY_TX;
            else if (i == 2 * RANDOM_WORDS / 3)
                idle_mode = IDLE_NONE;
            send_number(pick_number());
        end
        @(negedge clk);
        in_valid <= 1'b0;

        while (ledger.pending_count() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (ledger.mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // watchdog: ends a run that never drains with a mismatch report
    initial
    begin
        #100_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
